>>> sv/sas_pkg.sv
// Shared types, codes and size tables for the sprite attribute store and line evaluator.
package sas_pkg;

    localparam int SPRITE_COUNT = 128;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;

    localparam logic [1:0] BYTE_XLO  = 2'd0;
    localparam logic [1:0] BYTE_Y    = 2'd1;
    localparam logic [1:0] BYTE_CHR  = 2'd2;
    localparam logic [1:0] BYTE_ATTR = 2'd3;

    localparam logic [2:0] REG_BASE_SIZE     = 3'd0;
    localparam logic [2:0] REG_NAME_SELECT   = 3'd1;
    localparam logic [2:0] REG_TILEDATA_BASE = 3'd2;
    localparam logic [2:0] REG_INTERLACE     = 3'd3;
    localparam logic [2:0] REG_FIRST_OBJECT  = 3'd4;

    typedef struct packed {
        logic [2:0]  base_size;
        logic [1:0]  name_select;
        logic [15:0] tiledata_base;
        logic        interlace;
        logic [6:0]  first_object;
    } cfg_t;

    typedef struct packed {
        logic       we;
        logic [9:0] addr;
        logic [7:0] wdata;
    } oam_req_t;

    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
        logic [7:0] chr;
        logic [7:0] attr;
        logic       big;
    } sprite_t;

    typedef struct packed {
        logic [8:0]  x;
        logic [7:0]  row;
        logic [10:0] number;
        logic [2:0]  pal;
        logic [1:0]  prio;
        logic        hflip;
    } tile_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        tile_valid;
        logic [8:0]  tile_x;
        logic [7:0]  tile_row;
        logic [10:0] tile_number;
        logic [7:0]  tile_palette;
        logic [1:0]  tile_priority;
        logic        tile_hflip;
        logic        range_over;
        logic        time_over;
        logic        last;
    } beat_t;

    function automatic logic [6:0] size_w(input logic [2:0] b, input logic big);
        logic [6:0] w;
        if (big) begin
            unique case (b)
                3'd0: w = 7'd16;
                3'd1: w = 7'd32;
                3'd2: w = 7'd64;
                3'd3: w = 7'd32;
                3'd4: w = 7'd64;
                3'd5: w = 7'd64;
                3'd6: w = 7'd32;
                default: w = 7'd32;
            endcase
        end else begin
            unique case (b)
                3'd0: w = 7'd8;
                3'd1: w = 7'd8;
                3'd2: w = 7'd8;
                3'd3: w = 7'd16;
                3'd4: w = 7'd16;
                3'd5: w = 7'd32;
                3'd6: w = 7'd16;
                default: w = 7'd16;
            endcase
        end
        return w;
    endfunction

    function automatic logic [6:0] size_h(input logic [2:0] b, input logic big,
                                          input logic il);
        logic [6:0] h;
        if (big) begin
            unique case (b)
                3'd0: h = 7'd16;
                3'd1: h = 7'd32;
                3'd2: h = 7'd64;
                3'd3: h = 7'd32;
                3'd4: h = 7'd64;
                3'd5: h = 7'd64;
                3'd6: h = 7'd64;
                default: h = 7'd32;
            endcase
        end else begin
            unique case (b)
                3'd0: h = 7'd8;
                3'd1: h = 7'd8;
                3'd2: h = 7'd8;
                3'd3: h = 7'd16;
                3'd4: h = 7'd16;
                3'd5: h = 7'd32;
                3'd6: h = il ? 7'd16 : 7'd32;
                default: h = il ? 7'd16 : 7'd32;
            endcase
        end
        return h;
    endfunction

endpackage

>>> sv/sas_oam.sv
// Sprite attribute memories with byte access, sprite read port and clearing pass.
module sas_oam import sas_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  oam_req_t   req,
    output logic       clr_busy,
    output logic [7:0] rd_byte,
    output sprite_t    spr
);

    logic [7:0] xlo_mem  [SPRITE_COUNT];
    logic [8:0] y_mem    [SPRITE_COUNT];
    logic [7:0] chr_mem  [SPRITE_COUNT];
    logic [7:0] attr_mem [SPRITE_COUNT];
    logic [7:0] hi_mem   [SPRITE_COUNT/4];

    logic [7:0] clr_reg, clr_next;
    logic [7:0] xlo_q, chr_q, attr_q, hi_q;
    logic [8:0] y_q;
    logic [9:0] addr_q;
    logic [4:0] hidx;
    logic [2:0] hb;

    assign clr_busy = !clr_reg[7];
    assign clr_next = clr_busy ? clr_reg + 8'd1 : clr_reg;
    assign hidx     = req.addr[9] ? req.addr[4:0] : req.addr[8:4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= 8'd0;
        end else begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy) begin
            xlo_mem[clr_reg[6:0]]  <= 8'd0;
            y_mem[clr_reg[6:0]]    <= 9'd0;
            chr_mem[clr_reg[6:0]]  <= 8'd0;
            attr_mem[clr_reg[6:0]] <= 8'd0;
            hi_mem[clr_reg[4:0]]   <= 8'd0;
        end else if (req.we) begin
            if (req.addr[9]) begin
                hi_mem[req.addr[4:0]] <= req.wdata;
            end else begin
                unique case (req.addr[1:0])
                    BYTE_XLO:  xlo_mem[req.addr[8:2]]  <= req.wdata;
                    BYTE_Y:    y_mem[req.addr[8:2]]    <= {1'b0, req.wdata} + 9'd1;
                    BYTE_CHR:  chr_mem[req.addr[8:2]]  <= req.wdata;
                    default:   attr_mem[req.addr[8:2]] <= req.wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        xlo_q  <= xlo_mem[req.addr[8:2]];
        y_q    <= y_mem[req.addr[8:2]];
        chr_q  <= chr_mem[req.addr[8:2]];
        attr_q <= attr_mem[req.addr[8:2]];
        hi_q   <= hi_mem[hidx];
        addr_q <= req.addr;
    end

    assign hb = {addr_q[3:2], 1'b0};

    always_comb begin
        spr.x     = {hi_q[hb], xlo_q};
        spr.big   = hi_q[hb + 3'd1];
        spr.y     = y_q;
        spr.chr   = chr_q;
        spr.attr  = attr_q;
        if (addr_q[9]) begin
            rd_byte = hi_q;
        end else begin
            unique case (addr_q[1:0])
                BYTE_XLO: rd_byte = xlo_q;
                BYTE_Y:   rd_byte = 8'(y_q - 9'd1);
                BYTE_CHR: rd_byte = chr_q;
                default:  rd_byte = attr_q;
            endcase
        end
    end

endmodule

>>> sv/sas_seq.sv
// Request sequencer: byte access, sprite range scan, tile generation and result drain.
module sas_seq import sas_pkg::*; #(
    parameter int ITEM_LIMIT = 32,
    parameter int TILE_LIMIT = 34
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output beat_t       m_beat,
    output oam_req_t    oam_req,
    input  logic        clr_busy,
    input  logic [7:0]  rd_byte,
    input  sprite_t     spr
);

    localparam int CW  = $clog2(ITEM_LIMIT + 1);
    localparam int LW  = (ITEM_LIMIT > 1) ? $clog2(ITEM_LIMIT) : 1;
    localparam int TCW = $clog2(TILE_LIMIT + 1);
    localparam int TIW = (TILE_LIMIT > 1) ? $clog2(TILE_LIMIT) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD     = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_GBEGIN = 4'd3;
    localparam logic [3:0] ST_GLIST  = 4'd4;
    localparam logic [3:0] ST_GSPR   = 4'd5;
    localparam logic [3:0] ST_GPREP  = 4'd6;
    localparam logic [3:0] ST_GTILE  = 4'd7;
    localparam logic [3:0] ST_DBEGIN = 4'd8;
    localparam logic [3:0] ST_DRD    = 4'd9;
    localparam logic [3:0] ST_DLD    = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    typedef struct packed {
        logic [8:0]  ox;
        logic [3:0]  tw;
        logic [7:0]  row;
        logic [3:0]  cyn;
        logic [3:0]  cx;
        logic [10:0] tb;
        logic [2:0]  pal;
        logic [1:0]  prio;
        logic        hflip;
    } ctx_t;

    logic [3:0]     state_reg, state_next;
    logic [7:0]     ly_reg, ly_next;
    logic           field_reg, field_next;
    logic [7:0]     scan_reg, scan_next;
    logic           pend_reg, pend_next;
    logic [6:0]     pidx_reg, pidx_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [LW-1:0]  i_reg, i_next;
    logic [TCW-1:0] tiles_reg, tiles_next;
    logic [TCW-1:0] j_reg, j_next;
    logic [2:0]     tx_reg, tx_next;
    ctx_t           ctx_reg, ctx_next;
    logic           rover_reg, rover_next;
    logic           tover_reg, tover_next;
    beat_t          out_reg, out_next;

    logic [6:0] list_mem [ITEM_LIMIT];
    tile_t      tbuf_mem [TILE_LIMIT];
    logic [6:0] list_q;
    tile_t      tbuf_q;
    logic       list_we, tbuf_we;
    tile_t      tile_w;

    logic       s_acc;
    logic [6:0] scan_idx;
    logic [6:0] w, h, hh;
    logic [9:0] oxw, ysum, ly10;
    logic       hit;
    logic [7:0] r8, f8, w8, h8, row8;
    logic [8:0] r9;
    logic [15:0] tb16;
    logic [3:0] mx, cxm;
    logic [8:0] px;
    logic       skip;

    assign s_tready = (state_reg == ST_IDLE) && !clr_busy;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_beat   = out_reg;
    assign scan_idx = cfg.first_object + scan_reg[6:0];

    always_comb begin
        w    = size_w(cfg.base_size, spr.big);
        h    = size_h(cfg.base_size, spr.big, cfg.interlace);
        hh   = cfg.interlace ? (h >> 1) : h;
        oxw  = {1'b0, spr.x} + {3'b0, w} - 10'd1;
        ysum = {1'b0, spr.y} + {3'b0, hh};
        ly10 = {2'b0, ly_reg};
        hit  = !((spr.x > 9'd256) && (oxw < 10'd512)) &&
               (((ly10 >= {1'b0, spr.y}) && (ly10 < ysum)) ||
                ((ysum >= 10'd256) && (ly_reg < ysum[7:0])));

        r8 = ly_reg - spr.y[7:0];
        r9 = cfg.interlace ? {r8, 1'b0} : {1'b0, r8};
        w8 = {1'b0, w};
        h8 = {1'b0, h};
        if (!spr.attr[7]) begin
            f8 = r9[7:0];
        end else if (w == h) begin
            f8 = h8 - 8'd1 - r9[7:0];
        end else if (r9 < {2'b0, w}) begin
            f8 = w8 - 8'd1 - r9[7:0];
        end else begin
            f8 = (w8 << 1) + w8 - 8'd1 - r9[7:0];
        end
        if (!cfg.interlace) begin
            row8 = f8;
        end else if (spr.attr[7]) begin
            row8 = f8 - {7'd0, field_reg};
        end else begin
            row8 = f8 + {7'd0, field_reg};
        end
        tb16 = spr.attr[0] ?
               cfg.tiledata_base + {1'b0, 3'd1 + {1'b0, cfg.name_select}, 12'd0} :
               cfg.tiledata_base;

        mx   = ctx_reg.hflip ? (ctx_reg.tw - 4'd1 - {1'b0, tx_reg}) : {1'b0, tx_reg};
        cxm  = ctx_reg.cx + mx;
        px   = ctx_reg.ox + {3'd0, tx_reg, 3'd0};
        skip = (ctx_reg.ox != 9'd256) && px[8] && (({1'b0, px} + 10'd7) < 10'd512);

        tile_w.x      = px;
        tile_w.row    = ctx_reg.row;
        tile_w.number = ctx_reg.tb + {3'd0, ctx_reg.cyn, cxm};
        tile_w.pal    = ctx_reg.pal;
        tile_w.prio   = ctx_reg.prio;
        tile_w.hflip  = ctx_reg.hflip;
    end

    always_comb begin
        state_next = state_reg;
        ly_next    = ly_reg;
        field_next = field_reg;
        scan_next  = scan_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        tiles_next = tiles_reg;
        j_next     = j_reg;
        tx_next    = tx_reg;
        ctx_next   = ctx_reg;
        rover_next = rover_reg;
        tover_next = tover_reg;
        out_next   = out_reg;
        list_we    = 1'b0;
        tbuf_we    = 1'b0;
        oam_req.we    = 1'b0;
        oam_req.addr  = s_tdata[9:0];
        oam_req.wdata = s_tdata[17:10];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    ly_next    = s_tdata[25:18];
                    field_next = s_tdata[26];
                    priority case (s_tuser)
                        REQ_WRITE: oam_req.we = 1'b1;
                        REQ_READ:  state_next = ST_RD;
                        REQ_EVAL: begin
                            scan_next  = 8'd0;
                            cnt_next   = '0;
                            tiles_next = '0;
                            state_next = ST_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD: begin
                out_next            = '0;
                out_next.read_data  = rd_byte;
                out_next.range_over = rover_reg;
                out_next.time_over  = tover_reg;
                out_next.last       = 1'b1;
                state_next          = ST_OUT;
            end
            ST_SCAN: begin
                oam_req.addr = {1'b0, scan_idx, 2'b00};
                if (!scan_reg[7]) begin
                    scan_next = scan_reg + 8'd1;
                    pend_next = 1'b1;
                    pidx_next = scan_idx;
                end
                if (pend_reg && hit) begin
                    if (cnt_reg == CW'(ITEM_LIMIT)) begin
                        rover_next = 1'b1;
                        state_next = ST_GBEGIN;
                    end else begin
                        list_we  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (!pend_reg && scan_reg[7]) begin
                    state_next = ST_GBEGIN;
                end
            end
            ST_GBEGIN: begin
                i_next     = LW'(cnt_reg - 1'b1);
                state_next = (cnt_reg == '0) ? ST_DBEGIN : ST_GLIST;
            end
            ST_GLIST: begin
                state_next = ST_GSPR;
            end
            ST_GSPR: begin
                oam_req.addr = {1'b0, list_q, 2'b00};
                state_next   = ST_GPREP;
            end
            ST_GPREP: begin
                ctx_next.ox    = spr.x;
                ctx_next.tw    = w[6:3];
                ctx_next.row   = row8;
                ctx_next.cyn   = spr.chr[7:4] + row8[6:3];
                ctx_next.cx    = spr.chr[3:0];
                ctx_next.tb    = tb16[14:4];
                ctx_next.pal   = spr.attr[3:1];
                ctx_next.prio  = spr.attr[5:4];
                ctx_next.hflip = spr.attr[6];
                tx_next        = 3'd0;
                state_next     = ST_GTILE;
            end
            ST_GTILE: begin
                if (!skip && (tiles_reg == TCW'(TILE_LIMIT))) begin
                    tover_next = 1'b1;
                    state_next = ST_DBEGIN;
                end else begin
                    if (!skip) begin
                        tbuf_we    = 1'b1;
                        tiles_next = tiles_reg + 1'b1;
                    end
                    if ({1'b0, tx_reg} == ctx_reg.tw - 4'd1) begin
                        if (i_reg == '0) begin
                            state_next = ST_DBEGIN;
                        end else begin
                            i_next     = i_reg - 1'b1;
                            state_next = ST_GLIST;
                        end
                    end else begin
                        tx_next = tx_reg + 3'd1;
                    end
                end
            end
            ST_DBEGIN: begin
                j_next = '0;
                if (tiles_reg == '0) begin
                    out_next            = '0;
                    out_next.range_over = rover_reg;
                    out_next.time_over  = tover_reg;
                    out_next.last       = 1'b1;
                    state_next          = ST_OUT;
                end else begin
                    state_next = ST_DRD;
                end
            end
            ST_DRD: begin
                state_next = ST_DLD;
            end
            ST_DLD: begin
                out_next.read_data     = 8'd0;
                out_next.tile_valid    = 1'b1;
                out_next.tile_x        = tbuf_q.x;
                out_next.tile_row      = tbuf_q.row;
                out_next.tile_number   = tbuf_q.number;
                out_next.tile_palette  = {1'b1, tbuf_q.pal, 4'd0};
                out_next.tile_priority = tbuf_q.prio;
                out_next.tile_hflip    = tbuf_q.hflip;
                out_next.range_over    = rover_reg;
                out_next.time_over     = tover_reg;
                out_next.last          = (j_reg + 1'b1) == tiles_reg;
                state_next             = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (out_reg.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_DRD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[cnt_reg[LW-1:0]] <= pidx_reg;
        end
        list_q <= list_mem[i_reg];
        if (tbuf_we) begin
            tbuf_mem[tiles_reg[TIW-1:0]] <= tile_w;
        end
        tbuf_q <= tbuf_mem[j_reg[TIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            rover_reg <= 1'b0;
            tover_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            rover_reg <= rover_next;
            tover_reg <= tover_next;
        end
    end

    always_ff @(posedge aclk) begin
        ly_reg    <= ly_next;
        field_reg <= field_next;
        scan_reg  <= scan_next;
        pidx_reg  <= pidx_next;
        cnt_reg   <= cnt_next;
        i_reg     <= i_next;
        tiles_reg <= tiles_next;
        j_reg     <= j_next;
        tx_reg    <= tx_next;
        ctx_reg   <= ctx_next;
        out_reg   <= out_next;
    end

endmodule

>>> sv/sprite_attribute_store_and_line_eval_top.sv
// Top level: configuration registers, attribute store and evaluation sequencer.
// After reset the block clears its 128 sprite entries and accepts no beat until
// that pass ends. A byte read gives its beat from the registered memory read via
// the read state. An evaluate request scans the sprites through one read port at
// one sprite per cycle, ending early when the sprite limit cuts the scan short,
// then takes each collected sprite through the list, sprite and preparation
// states and the tile state for each tile position; each later tile beat passes
// the buffer read and load states after the previous one is taken. The block
// takes one request at a time and is not ready until the last result beat is taken.
module sprite_attribute_store_and_line_eval_top import sas_pkg::*; #(
    parameter int ITEM_LIMIT = 32,
    parameter int TILE_LIMIT = 34
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[9:0], write_data[17:10], line_y[25:18], field_parity[26], zero above.
    input  logic [31:0] s_tdata,
    // req_type[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], tile_x[16:8], tile_row[24:17], tile_number[35:25],
    // tile_palette[43:36], tile_priority[45:44], tile_hflip[46], range_over[47],
    // time_over[48], zero above.
    output logic [55:0] m_tdata,
    // tile_valid[0].
    output logic        m_tuser,
    output logic        m_tlast
);

    cfg_t     cfg_reg, cfg_next;
    oam_req_t oam_req;
    logic     clr_busy;
    logic [7:0] rd_byte;
    sprite_t  spr;
    beat_t    beat;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            priority case (paddr[4:2])
                REG_BASE_SIZE:     cfg_next.base_size     = pwdata[2:0];
                REG_NAME_SELECT:   cfg_next.name_select   = pwdata[1:0];
                REG_TILEDATA_BASE: cfg_next.tiledata_base = pwdata[15:0];
                REG_INTERLACE:     cfg_next.interlace     = pwdata[0];
                REG_FIRST_OBJECT:  cfg_next.first_object  = pwdata[6:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
        priority case (paddr[4:2])
            REG_BASE_SIZE:     prdata = {29'd0, cfg_reg.base_size};
            REG_NAME_SELECT:   prdata = {30'd0, cfg_reg.name_select};
            REG_TILEDATA_BASE: prdata = {16'd0, cfg_reg.tiledata_base};
            REG_INTERLACE:     prdata = {31'd0, cfg_reg.interlace};
            REG_FIRST_OBJECT:  prdata = {25'd0, cfg_reg.first_object};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sas_oam u_oam (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (oam_req),
        .clr_busy (clr_busy),
        .rd_byte  (rd_byte),
        .spr      (spr)
    );

    sas_seq #(
        .ITEM_LIMIT (ITEM_LIMIT),
        .TILE_LIMIT (TILE_LIMIT)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_beat   (beat),
        .oam_req  (oam_req),
        .clr_busy (clr_busy),
        .rd_byte  (rd_byte),
        .spr      (spr)
    );

    assign m_tdata = {7'd0, beat.time_over, beat.range_over, beat.tile_hflip,
                      beat.tile_priority, beat.tile_palette, beat.tile_number,
                      beat.tile_row, beat.tile_x, beat.read_data};
    assign m_tuser = beat.tile_valid;
    assign m_tlast = beat.last;

endmodule
